// ===== sv/paids_pkg.sv =====
// Shared types, codes and defaults of the positional list block.
package paids_pkg;

    localparam int DEPTH_DEF = 128;

    localparam int KIND_W   = 2;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 7;
    localparam int FILL_W   = 8;

    localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] K_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] K_SEARCH = 2'd2;
    localparam logic [KIND_W-1:0] K_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] read_value;
        logic [FOUND_W-1:0]       found_index;
        logic [FILL_W-1:0]        fill_count;
    } t_result;

    typedef struct packed {
        logic    busy;
        logic    done;
        t_result res;
    } t_core_rsp;

endpackage

// ===== sv/paids_core.sv =====
// Request sequencer, list memory and shared address walker of the positional list.
module paids_core #(
    parameter int DEPTH = paids_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  paids_pkg::t_req     i_req,
    input  logic                i_ack,
    output paids_pkg::t_core_rsp o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > paids_pkg::POS_W + 1) ? CW : paids_pkg::POS_W + 1;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_WALK = 2'd1;
    localparam logic [1:0] C_DONE = 2'd2;

    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
    localparam logic [EW-1:0] ONE_E   = EW'(1);

    logic [1:0]                          r_state;
    logic [CW-1:0]                       r_count;
    logic [paids_pkg::KIND_W-1:0]        r_kind;
    logic signed [paids_pkg::WORD_W-1:0] r_word;
    logic [AW-1:0]                       r_pos_addr;
    logic                                r_ok;
    logic [paids_pkg::STATUS_W-1:0]      r_status;
    logic [AW-1:0]                       r_addr;
    logic [CW-1:0]                       r_left;
    logic [AW-1:0]                       r_rd_addr_q;
    logic                                r_vld_q;
    logic signed [paids_pkg::WORD_W-1:0] r_rd_data;
    logic signed [paids_pkg::WORD_W-1:0] r_rd_val;
    logic [AW-1:0]                       r_found;

    logic signed [paids_pkg::WORD_W-1:0] mem [DEPTH];

    logic [EW-1:0]                       w_cnt_e;
    logic [EW-1:0]                       w_pos_e;
    logic                                w_hit;
    logic                                w_end;
    logic                                w_rd_en;
    logic                                w_we;
    logic [AW-1:0]                       w_waddr;
    logic signed [paids_pkg::WORD_W-1:0] w_wdata;
    logic [AW+paids_pkg::FOUND_W-1:0]    w_found_x;
    logic [CW+paids_pkg::FILL_W-1:0]     w_fill_x;

    assign w_cnt_e = EW'(r_count);
    assign w_pos_e = EW'(i_req.position);

    assign w_hit = (r_state == C_WALK) && r_vld_q && (r_kind == paids_pkg::K_SEARCH)
                   && (r_rd_data == r_word);
    assign w_end = (r_state == C_WALK) && (r_left == '0) && !r_vld_q;
    assign w_rd_en = (r_state == C_WALK) && (r_left != '0);

    // Moves write one slot beside the word just read; insert finishes with the new word.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos_addr;
        w_wdata = r_word;
        if (r_state == C_WALK && r_ok) begin
            if (r_vld_q && r_kind == paids_pkg::K_INSERT) begin
                w_we    = 1'b1;
                w_waddr = r_rd_addr_q + AW'(1);
                w_wdata = r_rd_data;
            end else if (r_vld_q && r_kind == paids_pkg::K_DELETE) begin
                w_we    = 1'b1;
                w_waddr = r_rd_addr_q - AW'(1);
                w_wdata = r_rd_data;
            end else if (w_end && r_kind == paids_pkg::K_INSERT) begin
                w_we    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_count <= '0;
            r_vld_q <= 1'b0;
            r_left  <= '0;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    r_vld_q <= 1'b0;
                    if (i_start) begin
                        r_kind     <= i_req.kind;
                        r_word     <= i_req.value;
                        r_pos_addr <= AW'(w_pos_e - ONE_E);
                        r_rd_val   <= '0;
                        r_found    <= '0;
                        r_ok       <= 1'b0;
                        r_left     <= '0;
                        r_state    <= C_WALK;
                        priority if (i_req.kind == paids_pkg::K_INSERT) begin
                            priority if (w_cnt_e >= DEPTH_E) begin
                                r_status <= paids_pkg::ST_FULL;
                            end else if (w_pos_e == '0 || w_pos_e > w_cnt_e + ONE_E) begin
                                r_status <= paids_pkg::ST_BADPOS;
                            end else begin
                                r_status <= paids_pkg::ST_OK;
                                r_ok     <= 1'b1;
                                r_addr   <= AW'(w_cnt_e - ONE_E);
                                r_left   <= CW'(w_cnt_e - w_pos_e + ONE_E);
                            end
                        end else if (r_count == '0) begin
                            r_status <= paids_pkg::ST_EMPTY;
                        end else if (i_req.kind == paids_pkg::K_SEARCH) begin
                            r_status <= paids_pkg::ST_NOTFOUND;
                            r_ok     <= 1'b1;
                            r_addr   <= '0;
                            r_left   <= r_count;
                        end else if (w_pos_e == '0 || w_pos_e > w_cnt_e) begin
                            r_status <= paids_pkg::ST_BADPOS;
                        end else if (i_req.kind == paids_pkg::K_DELETE) begin
                            r_status <= paids_pkg::ST_OK;
                            r_ok     <= 1'b1;
                            r_addr   <= AW'(w_pos_e);
                            r_left   <= CW'(w_cnt_e - w_pos_e);
                        end else begin
                            r_status <= paids_pkg::ST_OK;
                            r_ok     <= 1'b1;
                            r_addr   <= AW'(w_pos_e - ONE_E);
                            r_left   <= CW'(1);
                        end
                    end
                end
                C_WALK: begin
                    if (w_hit) begin
                        // first match wins: drop the read already in flight
                        r_status <= paids_pkg::ST_OK;
                        r_found  <= r_rd_addr_q;
                        r_left   <= '0;
                        r_vld_q  <= 1'b0;
                    end else if (r_left != '0) begin
                        r_rd_addr_q <= r_addr;
                        r_addr      <= (r_kind == paids_pkg::K_INSERT) ? r_addr - AW'(1)
                                                                       : r_addr + AW'(1);
                        r_left      <= r_left - CW'(1);
                        r_vld_q     <= 1'b1;
                    end else begin
                        r_vld_q <= 1'b0;
                    end
                    if (r_vld_q && r_kind == paids_pkg::K_READ) begin
                        r_rd_val <= r_rd_data;
                    end
                    if (w_end) begin
                        r_state <= C_DONE;
                        if (r_ok && r_kind == paids_pkg::K_INSERT) begin
                            r_count <= r_count + CW'(1);
                        end else if (r_ok && r_kind == paids_pkg::K_DELETE) begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                C_DONE: begin
                    if (i_ack) begin
                        r_state <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    assign w_found_x = {{paids_pkg::FOUND_W{1'b0}}, r_found};
    assign w_fill_x  = {{paids_pkg::FILL_W{1'b0}}, r_count};

    always_comb begin
        o_rsp.busy                = (r_state != C_IDLE);
        o_rsp.done                = (r_state == C_DONE);
        o_rsp.res.status          = r_status;
        o_rsp.res.read_value      = r_rd_val;
        o_rsp.res.found_index     = w_found_x[paids_pkg::FOUND_W-1:0];
        o_rsp.res.fill_count      = w_fill_x[paids_pkg::FILL_W-1:0];
    end

endmodule

// ===== sv/positional_array_insert_delete_search_top.sv =====
// Top level of the positional list with insert, delete, search and read.
//
// Request channel: i_valid / o_ready carry i_kind, i_value and i_position.
// Response channel: o_valid / i_ready carry o_status, o_read_value,
// o_found_index and o_fill_count, one response per request.
// A transaction completes at a rising edge with valid and ready both high.
//
// Walk: a request walks the list memory through one shared address
// counter with a registered read, one word per cycle. Insert and delete
// walk the moved words, search the words scanned, and read one word;
// a rejected request walks none. o_ready is low while a request is in
// progress.
//
// Reset: synchronous, active low; the fill count and all handshake state
// clear at once. List contents are not cleared; only written entries are read.
//
// Stall: the response sits in an output register until taken. A new request
// may be accepted meanwhile; its result waits in the sequencer until the
// output register frees up.
module positional_array_insert_delete_search_top #(
    parameter int DEPTH = paids_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [paids_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [paids_pkg::WORD_W-1:0] i_value,
    input  logic [paids_pkg::POS_W-1:0]         i_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [paids_pkg::STATUS_W-1:0]      o_status,
    output logic signed [paids_pkg::WORD_W-1:0] o_read_value,
    output logic [paids_pkg::FOUND_W-1:0]       o_found_index,
    output logic [paids_pkg::FILL_W-1:0]        o_fill_count
);

    paids_pkg::t_req      w_req;
    paids_pkg::t_core_rsp w_rsp;
    paids_pkg::t_result   r_out;
    logic                 r_out_valid;
    logic                 w_start;
    logic                 w_ack;

    assign w_req.kind     = i_kind;
    assign w_req.value    = i_value;
    assign w_req.position = i_position;

    assign o_ready = !w_rsp.busy;
    assign w_start = i_valid && o_ready;
    // output register is free when empty or being drained this cycle
    assign w_ack   = !r_out_valid || i_ready;

    paids_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .i_ack   (w_ack),
        .o_rsp   (w_rsp)
    );

    // Hold the response until taken; load the next one as soon as the slot frees.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rsp.done && w_ack) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.done && w_ack) begin
            r_out <= w_rsp.res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_read_value  = r_out.read_value;
    assign o_found_index = r_out.found_index;
    assign o_fill_count  = r_out.fill_count;

endmodule

// ===== sv/paids_checker.sv =====
// Port-level checker of the positional list, bound to the top level.
module paids_checker #(
    parameter int DEPTH = paids_pkg::DEPTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic [paids_pkg::KIND_W-1:0]        i_kind,
    input logic signed [paids_pkg::WORD_W-1:0] i_value,
    input logic [paids_pkg::POS_W-1:0]         i_position,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic [paids_pkg::STATUS_W-1:0]      o_status,
    input logic signed [paids_pkg::WORD_W-1:0] o_read_value,
    input logic [paids_pkg::FOUND_W-1:0]       o_found_index,
    input logic [paids_pkg::FILL_W-1:0]        o_fill_count
);

    localparam logic [paids_pkg::FILL_W-1:0] FULL_FILL = paids_pkg::FILL_W'(DEPTH);

    // Hold a stalled response.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_read_value)
                                && $stable(o_found_index) && $stable(o_fill_count))
        else $error("stalled response changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != paids_pkg::ST_OK |-> o_read_value == 0 && o_found_index == 0)
        else $error("failed request returned data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == paids_pkg::ST_FULL |-> o_fill_count == FULL_FILL)
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == paids_pkg::ST_EMPTY |-> o_fill_count == 0)
        else $error("empty status with entries present");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("response or busy after reset");

endmodule

bind positional_array_insert_delete_search_top paids_checker #(.DEPTH(DEPTH)) u_paids_checker (.*);

// ===== tb/sv/list_op_checker.sv =====
// Response checker for the positional list: predicts each response and compares it.
`timescale 1ns / 100ps

module list_op_checker
    import paids_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [WORD_W-1:0]   i_value,
    input  logic [POS_W-1:0]           i_position,
    input  logic                       i_rsp_valid,
    input  logic                       i_rsp_ready,
    input  logic [STATUS_W-1:0]        i_status,
    input  logic signed [WORD_W-1:0]   i_read_value,
    input  logic [FOUND_W-1:0]         i_found_index,
    input  logic [FILL_W-1:0]          i_fill_count,
    output int                         o_outstanding,
    output int                         o_mismatches
);

    logic signed [WORD_W-1:0] list_words [DEPTH];
    int                       list_len;
    t_result                  awaited_rsp [$];
    int                       mismatch_cnt = 0;

    // Apply one request to the shadow list and return the response it must give.
    function automatic t_result apply_list_op(input logic [KIND_W-1:0] kind,
                                              input logic signed [WORD_W-1:0] value,
                                              input logic [POS_W-1:0] position);
        t_result rsp;
        int      idx;
        int      pos;
        bit      hit;
        rsp    = '0;
        rsp.status = ST_OK;
        pos    = int'(position);
        hit    = 1'b0;
        case (kind)
            K_INSERT: begin
                if (list_len >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (pos < 1 || pos > list_len + 1) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (idx = list_len; idx > pos - 1; idx--)
                        list_words[idx] = list_words[idx - 1];
                    list_words[pos - 1] = value;
                    list_len++;
                end
            end
            K_DELETE: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos < 1 || pos > list_len) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (idx = pos - 1; idx + 1 < list_len; idx++)
                        list_words[idx] = list_words[idx + 1];
                    list_len--;
                end
            end
            K_SEARCH: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.status = ST_NOTFOUND;
                    for (idx = 0; idx < list_len && !hit; idx++) begin
                        if (list_words[idx] == value) begin
                            hit             = 1'b1;
                            rsp.status      = ST_OK;
                            rsp.found_index = FOUND_W'(idx);
                        end
                    end
                end
            end
            default: begin
                if (list_len == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (pos < 1 || pos > list_len) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    rsp.read_value = list_words[pos - 1];
                end
            end
        endcase
        rsp.fill_count = FILL_W'(list_len);
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            list_len = 0;
            awaited_rsp.delete();
        end else begin
            if (i_req_valid && i_req_ready)
                awaited_rsp.push_back(apply_list_op(i_kind, i_value, i_position));
            if (i_rsp_valid && i_rsp_ready) begin
                got.status      = i_status;
                got.read_value  = i_read_value;
                got.found_index = i_found_index;
                got.fill_count  = i_fill_count;
                if (awaited_rsp.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: response with no request pending", $realtime);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display({"%0t: mismatch status %0d/%0d read_value %0d/%0d",
                                      " found_index %0d/%0d fill_count %0d/%0d",
                                      " (expected/actual)"},
                                     $realtime, want.status, got.status,
                                     want.read_value, got.read_value,
                                     want.found_index, got.found_index,
                                     want.fill_count, got.fill_count);
                    end
                end
            end
        end
        o_outstanding <= awaited_rsp.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: drives list requests and response stalls, and gives the verdict.
`timescale 1ns / 100ps

module tb;
    import paids_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 2000;
    // The tail wait covers the longest request, which walks the whole list.
    localparam int TAIL_CYCLES  = LIST_DEPTH + 8;
    localparam int POOL_SIZE    = 8;
    localparam int RECENT_MAX   = 16;

    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] WORD_MAX = ~WORD_MIN;

    // Random phases steer the list toward full, toward empty, or keep it mixed.
    typedef enum logic [1:0] {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } t_phase;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       o_ready;
    logic [KIND_W-1:0]          i_kind       = K_INSERT;
    logic signed [WORD_W-1:0]   i_value      = '0;
    logic [POS_W-1:0]           i_position   = '0;
    logic                       o_valid;
    logic                       i_ready      = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic signed [WORD_W-1:0]   o_read_value;
    logic [FOUND_W-1:0]         o_found_index;
    logic [FILL_W-1:0]          o_fill_count;

    int                         outstanding;
    int                         mismatches;

    // Stimulus bookkeeping only: a rough fill level to aim positions, plus
    // word sources that make searches hit at shallow and deep indexes.
    int                         fill_est     = 0;
    bit                         idle_off     = 1'b0;
    logic signed [WORD_W-1:0]   word_pool [POOL_SIZE];
    logic signed [WORD_W-1:0]   recent_words [$];

    always #2 i_clk = ~i_clk;

    positional_array_insert_delete_search_top #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_found_index(o_found_index),
        .o_fill_count (o_fill_count)
    );

    list_op_checker #(
        .DEPTH(LIST_DEPTH)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_rsp_valid  (o_valid),
        .i_rsp_ready  (i_ready),
        .i_status     (o_status),
        .i_read_value (o_read_value),
        .i_found_index(o_found_index),
        .i_fill_count (o_fill_count),
        .o_outstanding(outstanding),
        .o_mismatches (mismatches)
    );

    // Present one request and hold it until the block takes the transaction.
    // Called just after the clock rises; returns once the block has accepted the request.
    task automatic send_req(input logic [KIND_W-1:0] kind,
                            input logic signed [WORD_W-1:0] value,
                            input logic [POS_W-1:0] position);
        int gap;
        int pos;
        gap = idle_off ? 0 : $urandom_range(0, 13);
        pos = int'(position);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_value    <= value;
        i_position <= position;
        do @(posedge i_clk); while (!o_ready);
        // Advance the fill estimate the way a good request would move it.
        if (kind == K_INSERT && fill_est < LIST_DEPTH && pos >= 1 && pos <= fill_est + 1) begin
            fill_est++;
            recent_words.push_back(value);
            if (recent_words.size() > RECENT_MAX)
                void'(recent_words.pop_front());
        end else if (kind == K_DELETE && fill_est > 0 && pos >= 1 && pos <= fill_est) begin
            fill_est--;
        end
    endtask

    // Drop valid and hold off until every pending response has been taken.
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(input t_phase phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_GROW:   return r < 70 ? K_INSERT : r < 80 ? K_DELETE : r < 90 ? K_SEARCH : K_READ;
            PH_SHRINK: return r < 70 ? K_DELETE : r < 80 ? K_INSERT : r < 90 ? K_SEARCH : K_READ;
            default:   return r < 25 ? K_INSERT : r < 50 ? K_DELETE : r < 75 ? K_SEARCH : K_READ;
        endcase
    endfunction

    // Insert draws half from a small pool (duplicates), half fresh words;
    // search half the time looks for words inserted lately, which may sit deep.
    function automatic logic signed [WORD_W-1:0] pick_value(input logic [KIND_W-1:0] kind);
        int r;
        r = $urandom_range(0, 3);
        if (kind == K_INSERT)
            return r < 2 ? word_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
        if (kind == K_SEARCH) begin
            if (r < 2 && recent_words.size() > 0)
                return recent_words[$urandom_range(0, recent_words.size() - 1)];
            return r == 2 ? word_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
        end
        return $urandom;
    endfunction

    // Mostly legal positions with weight on both ends, then the illegal ones.
    function automatic logic [POS_W-1:0] pick_position(input logic [KIND_W-1:0] kind);
        int r;
        int hi;
        hi = (kind == K_INSERT) ? fill_est + 1 : fill_est;
        if (hi > 255)
            hi = 255;
        if (hi < 1)
            hi = 1;
        r = $urandom_range(0, 99);
        if (r < 15)
            return POS_W'(1);
        if (r < 30)
            return POS_W'(hi);
        if (r < 80)
            return POS_W'($urandom_range(1, hi));
        if (r < 86)
            return POS_W'(0);
        if (r < 92)
            return POS_W'(hi + 1 > 255 ? 255 : hi + 1);
        if (r < 96)
            return {POS_W{1'b1}};
        return POS_W'($urandom_range(0, 255));
    endfunction

    // Request side: reset, directed cases, then random phases.
    initial begin
        t_phase             phase;
        logic [KIND_W-1:0]  kind;
        int                 sent;
        int                 span;
        int                 n;

        word_pool[0] = '0;
        word_pool[1] = -1;
        word_pool[2] = WORD_MIN;
        word_pool[3] = WORD_MAX;
        for (int k = 4; k < POOL_SIZE; k++)
            word_pool[k] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: every kind but insert reports empty.
        send_req(K_DELETE, '0, 8'd1);
        send_req(K_SEARCH, '0, 8'd1);
        send_req(K_READ,   '0, 8'd1);
        // Insert at position zero and past the end.
        send_req(K_INSERT, 32'sd7, 8'd0);
        send_req(K_INSERT, 32'sd7, 8'd2);
        // Build a list with the word extremes, inserting at front, middle and end.
        send_req(K_INSERT, WORD_MIN, 8'd1);
        send_req(K_INSERT, WORD_MAX, 8'd2);
        send_req(K_INSERT, -32'sd1, 8'd1);
        send_req(K_INSERT, '0, 8'd2);
        send_req(K_INSERT, 32'sd9, 8'd255);
        // Read out of range, at the end and at the front.
        send_req(K_READ,   '0, 8'd0);
        send_req(K_READ,   '0, 8'd5);
        send_req(K_READ,   '0, 8'd4);
        send_req(K_READ,   '0, 8'd1);
        // Search hits at the last and first index, and a miss.
        send_req(K_SEARCH, WORD_MAX, 8'd0);
        send_req(K_SEARCH, -32'sd1, 8'd255);
        send_req(K_SEARCH, 32'sd12345, 8'd1);
        // Delete out of range, then last, first and middle entries.
        send_req(K_DELETE, '0, 8'd0);
        send_req(K_DELETE, '0, 8'd255);
        send_req(K_DELETE, '0, 8'd4);
        send_req(K_DELETE, '0, 8'd1);
        send_req(K_INSERT, 32'sh5A5A_A5A5, 8'd3);
        send_req(K_DELETE, '0, 8'd2);
        hold_until_drained();

        // Grow and shrink phases keep going until the list is full or empty (at most 600 requests a phase),
        // so the full and empty cases come up with real contents around them.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase    = t_phase'($urandom_range(0, 2));
            idle_off = ($urandom_range(0, 3) == 0);
            span     = $urandom_range(40, 160);
            n        = 0;
            while (n < 600 && (n < span ||
                   (phase == PH_GROW && fill_est < LIST_DEPTH) ||
                   (phase == PH_SHRINK && fill_est > 0))) begin
                kind = pick_kind(phase);
                send_req(kind, pick_value(kind), pick_position(kind));
                n++;
                sent++;
            end
            // Let the block run dry between phases.
            hold_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Response side: draw a stall per transaction, then take the next response.
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
